// ===== rtl/core/kesc_pkg.sv =====
// ----------------------------------------------------------------------------
// kesc_pkg
// shared types and constants of the key event state checker
// ----------------------------------------------------------------------------
`default_nettype none

package kesc_pkg;

    localparam int unsigned NUM_KEYS_DEF = 1024;

    localparam logic [4:0]         KIND_KEY    = 5'd1;
    localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
    localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
    localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

    typedef enum logic [1:0] {
        VIOL_NONE           = 2'd0,
        VIOL_DOUBLE_PRESS   = 2'd1,
        VIOL_ORPHAN_REPEAT  = 2'd2,
        VIOL_ORPHAN_RELEASE = 2'd3
    } t_viol;

    typedef struct packed {
        logic [4:0]         event_kind;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } t_in_beat;

    typedef struct packed {
        logic  drop;
        t_viol violation;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/core/kesc_ram.sv =====
// ----------------------------------------------------------------------------
// kesc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kesc_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/kesc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// kesc_out_fifo
// two-entry result queue that decouples the check stage from the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module kesc_out_fifo
    import kesc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_beat i_push_beat,
    input  wire logic      i_pop,
    output logic           o_valid,
    output t_out_beat      o_beat,
    output logic [1:0]     o_count
);

    t_out_beat  r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_beat;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_beat  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/key_event_state_checker.sv =====
// ----------------------------------------------------------------------------
// key_event_state_checker
// checks key events against a pressed mark per key code held in a ram
// ----------------------------------------------------------------------------
// path: an accepted beat is registered in the check stage, its result is then
// registered in the result queue, from which it is offered
// throughput: one beat per cycle while the queue has room, set by the single
// read-modify-write per event on the mark ram (one read port, one write port)
// reset: a clearing pass writes every mark to zero with o_in_ready low,
// then beats are taken
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_state_checker
    import kesc_pkg::*;
#(
    parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
    localparam int unsigned AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_beat,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_beat
);

    // clearing pass after reset
    logic          r_clr_done;
    logic [AW-1:0] r_clr_addr;

    // check stage, holds the beat whose mark is being read
    logic          r_s1_valid;
    t_in_beat      r_s1_beat;

    // last write, forwarded to a read issued at the same edge
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic          r_fwd_data;

    logic          in_accept;
    logic          out_pop;
    logic [1:0]    fifo_count;
    logic [2:0]    occupancy;

    logic          ram_rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    logic [AW-1:0] s1_addr;
    logic          s1_checked;
    logic          s1_down;
    logic          s1_wr;
    logic          s1_wr_data;
    t_out_beat     s1_result;

    // ------------------------------------------------------------------------
    // input handshake: an accepted beat must find room in the queue,
    // counting the one in the check stage and a pop in this cycle
    // ------------------------------------------------------------------------
    assign out_pop    = o_out_valid & i_out_ready;
    assign occupancy  = {1'b0, fifo_count} + {2'b00, r_s1_valid};
    assign o_in_ready = r_clr_done & ((occupancy < 3'd2) | out_pop);
    assign in_accept  = i_in_valid & o_in_ready;

    // ------------------------------------------------------------------------
    // clearing pass
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (!r_clr_done) begin
            if (r_clr_addr == AW'(NUM_KEYS - 1)) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // check stage
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_beat <= i_in_beat;
        end
    end

    assign s1_addr    = r_s1_beat.event_code[AW-1:0];
    assign s1_checked = (r_s1_beat.event_kind == KIND_KEY) &&
                        ({1'b0, r_s1_beat.event_code} < 17'(NUM_KEYS));

    // mark as of the read edge, with the write of that same edge folded in
    assign s1_down = (r_fwd_valid && (r_fwd_addr == s1_addr)) ? r_fwd_data
                                                             : ram_rd_data;

    always_comb begin
        s1_result.violation = VIOL_NONE;
        s1_wr               = 1'b0;
        s1_wr_data          = 1'b0;
        if (s1_checked) begin
            if (r_s1_beat.event_value == VAL_PRESS) begin
                if (s1_down) begin
                    s1_result.violation = VIOL_DOUBLE_PRESS;
                end
                s1_wr      = 1'b1;
                s1_wr_data = 1'b1;
            end else if (r_s1_beat.event_value == VAL_REPEAT) begin
                if (!s1_down) begin
                    s1_result.violation = VIOL_ORPHAN_REPEAT;
                end
            end else if (r_s1_beat.event_value == VAL_RELEASE) begin
                if (!s1_down) begin
                    s1_result.violation = VIOL_ORPHAN_RELEASE;
                end
                s1_wr      = 1'b1;
                s1_wr_data = 1'b0;
            end
        end
        s1_result.drop = (s1_result.violation != VIOL_NONE);
    end

    // ------------------------------------------------------------------------
    // mark ram write port: clearing pass first, then check stage updates
    // ------------------------------------------------------------------------
    always_comb begin
        if (!r_clr_done) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 1'b0;
        end else begin
            wr_en   = r_s1_valid & s1_wr;
            wr_addr = s1_addr;
            wr_data = s1_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= wr_addr;
        r_fwd_data <= wr_data;
    end

    kesc_ram #(
        .WIDTH (1),
        .DEPTH (NUM_KEYS)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (i_in_beat.event_code[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------------
    // result queue, every accepted beat lands here in its check cycle
    // ------------------------------------------------------------------------
    kesc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_beat (s1_result),
        .i_pop       (out_pop),
        .o_valid     (o_out_valid),
        .o_beat      (o_out_beat),
        .o_count     (fifo_count)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the key event state checker: directed key rule
// sequences, pass-through cases and a long random stream are sent through
// the input channel, every verdict is predicted from a private pressed-mark
// table and compared against the output channel in order
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import kesc_pkg::*;

    localparam int unsigned NUM_KEYS      = NUM_KEYS_DEF;
    localparam int unsigned RANDOM_CHECKS = 1900;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_CYCLES  = 10;

    // dut ports, all inputs known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    // predictor state: one pressed mark per key code
    bit        key_is_down [NUM_KEYS];
    // verdicts predicted for accepted beats, oldest first
    t_out_beat expected_verdicts [$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned checked_beats = 0;

    // sender burst bookkeeping
    int unsigned burst_left = 0;

    // receiver long hold-off request, taken over by the receiver process
    int unsigned hold_request = 0;

    key_event_state_checker #(
        .NUM_KEYS (NUM_KEYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, catches a hung handshake or a lost verdict
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // verdict of one event against the pressed marks, updates the marks
    function automatic t_out_beat predict_key_check(input t_in_beat beat);
        t_out_beat verdict;
        bit        down;
        verdict.drop      = 1'b0;
        verdict.violation = VIOL_NONE;
        if (beat.event_kind == KIND_KEY && beat.event_code < NUM_KEYS) begin
            down = key_is_down[beat.event_code];
            if (beat.event_value == VAL_PRESS) begin
                // press on a key already down
                if (down) begin
                    verdict.violation = VIOL_DOUBLE_PRESS;
                end
                key_is_down[beat.event_code] = 1'b1;
            end else if (beat.event_value == VAL_REPEAT) begin
                // repeat with no press before it, mark stays
                if (!down) begin
                    verdict.violation = VIOL_ORPHAN_REPEAT;
                end
            end else if (beat.event_value == VAL_RELEASE) begin
                // release of a key that is up
                if (!down) begin
                    verdict.violation = VIOL_ORPHAN_RELEASE;
                end
                key_is_down[beat.event_code] = 1'b0;
            end
            // any other value passes and leaves the mark alone
        end
        verdict.drop = (verdict.violation != VIOL_NONE);
        return verdict;
    endfunction

    // predict on every accepted input beat, compare every accepted output beat
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_verdicts.push_back(predict_key_check(i_in_beat));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("verdict beat with no event waiting for it");
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_out_beat.drop !== want.drop) begin
                        $error("drop: expected %0d, actual %0d",
                               want.drop, o_out_beat.drop);
                        error_count++;
                    end
                    if (o_out_beat.violation !== want.violation) begin
                        $error("violation: expected %0d, actual %0d",
                               want.violation, o_out_beat.violation);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver: random stall modes of random length, plus long hold-offs
    always @(posedge i_clk) begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned rx_mode;
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(4, 80);
            end
            mode_left--;
            case (rx_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    // mostly stalled
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    // mostly ready
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    function automatic t_in_beat key_beat(input logic [15:0] code,
                                          input logic signed [31:0] value);
        t_in_beat beat;
        beat.event_kind  = KIND_KEY;
        beat.event_code  = code;
        beat.event_value = value;
        return beat;
    endfunction

    // offer one beat and hold it until it is taken; bursts with random gaps
    task automatic send_beat(input t_in_beat beat);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // now and then a long burst with no idle cycles
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        burst_left--;
        if (beat.event_kind == KIND_KEY && beat.event_code < NUM_KEYS) begin
            checked_beats++;
        end
    endtask

    // sender stops until every predicted verdict has come back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // press, repeat and release rules, both clean and broken, on one key and on the lowest and highest codes
    task automatic test_key_rules();
        send_beat(key_beat(16'd5, VAL_RELEASE));   // orphan release
        send_beat(key_beat(16'd5, VAL_REPEAT));    // orphan repeat
        send_beat(key_beat(16'd5, VAL_PRESS));
        send_beat(key_beat(16'd5, VAL_PRESS));     // double press
        send_beat(key_beat(16'd5, VAL_REPEAT));
        send_beat(key_beat(16'd5, VAL_RELEASE));
        send_beat(key_beat(16'd5, VAL_RELEASE));   // orphan release again
        // lowest and highest checked codes
        send_beat(key_beat(16'd0, VAL_PRESS));
        send_beat(key_beat(16'(NUM_KEYS - 1), VAL_PRESS));
        send_beat(key_beat(16'(NUM_KEYS - 1), VAL_REPEAT));
        send_beat(key_beat(16'(NUM_KEYS - 1), VAL_RELEASE));
        wait_for_drain();
    endtask

    // codes at or above the table size pass and touch no mark
    task automatic test_out_of_range_codes();
        send_beat(key_beat(16'(NUM_KEYS), VAL_RELEASE));
        send_beat(key_beat(16'hffff, VAL_REPEAT));
        send_beat(key_beat(16'hffff, VAL_PRESS));
        wait_for_drain();
    endtask

    // non-key kinds pass even with key-like values, also on a pressed key
    task automatic test_non_key_events();
        t_in_beat beat;
        beat = key_beat(16'd0, VAL_PRESS);
        beat.event_kind = 5'd0;
        send_beat(beat);
        beat.event_kind = 5'd31;
        beat.event_value = VAL_RELEASE;
        send_beat(beat);
        beat.event_kind = 5'd2;
        beat.event_code = 16'd7;
        beat.event_value = VAL_REPEAT;
        send_beat(beat);
        wait_for_drain();
    endtask

    // values other than release, press or repeat pass and keep the mark
    task automatic test_odd_values();
        send_beat(key_beat(16'd9, -32'sd1));
        send_beat(key_beat(16'd9, 32'sd3));
        send_beat(key_beat(16'd9, 32'sh8000_0000));
        send_beat(key_beat(16'd9, 32'sh7fff_ffff));
        send_beat(key_beat(16'd9, 32'sh0001_0001));
        // key 9 still up, key 0 still down from the earlier press
        send_beat(key_beat(16'd9, VAL_REPEAT));
        send_beat(key_beat(16'd0, VAL_RELEASE));
        wait_for_drain();
    endtask

    // key codes cluster on a few keys so marks interact
    function automatic logic [15:0] pick_key_code();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return 16'($urandom_range(0, 7));
        end else if (pick < 8) begin
            return 16'(NUM_KEYS - 1 - $urandom_range(0, 7));
        end
        return 16'($urandom_range(0, NUM_KEYS - 1));
    endfunction

    function automatic logic signed [31:0] pick_key_value();
        case ($urandom_range(0, 2))
            0: return VAL_RELEASE;
            1: return VAL_PRESS;
            default: return VAL_REPEAT;
        endcase
    endfunction

    // receiver holds off while the sender keeps offering, input must stall
    task automatic test_back_pressure();
        logic [15:0] code;
        hold_request = 300;
        repeat (60) begin
            code = pick_key_code();
            send_beat(key_beat(code, pick_key_value()));
        end
        wait_for_drain();
    endtask

    // clean keystrokes, loose key events and random noise
    task automatic test_random_stream();
        int unsigned start;
        int unsigned pick;
        int unsigned reps;
        logic [15:0] code;
        t_in_beat    beat;
        start = checked_beats;
        while (checked_beats - start < RANDOM_CHECKS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // well-formed stroke: press, a few repeats, release
                code = pick_key_code();
                reps = $urandom_range(0, 3);
                send_beat(key_beat(code, VAL_PRESS));
                repeat (reps) send_beat(key_beat(code, VAL_REPEAT));
                send_beat(key_beat(code, VAL_RELEASE));
            end else if (pick < 85) begin
                // loose key event, breaks strokes in progress
                send_beat(key_beat(pick_key_code(), pick_key_value()));
            end else if (pick < 92) begin
                // key-like values on codes past the table
                code = 16'($urandom_range(NUM_KEYS, 16'hffff));
                send_beat(key_beat(code, pick_key_value()));
            end else begin
                // every field random
                beat.event_kind  = ($urandom_range(0, 1) == 1) ? KIND_KEY
                                                               : 5'($urandom_range(0, 31));
                beat.event_code  = 16'($urandom);
                beat.event_value = 32'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    beat.event_code = 16'($urandom_range(0, NUM_KEYS - 1));
                end
                send_beat(beat);
            end
        end
        wait_for_drain();
    endtask

    initial begin
        // reset held low first; the dut then clears its marks on its own
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_key_rules();
        test_out_of_range_codes();
        test_non_key_events();
        test_odd_values();
        test_back_pressure();
        test_random_stream();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kesc_pkg.sv
rtl/core/kesc_ram.sv
rtl/core/kesc_out_fifo.sv
rtl/core/key_event_state_checker.sv
verif/testbench.sv
